// ----- rtl/core/i2cm_pkg.sv -----
// Shared types and constants for the I2C master byte engine.
package i2cm_pkg;

  // Command codes as they arrive on the command field
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  // Configuration register indexes
  localparam logic CfgUnitTicks  = 1'b0;
  localparam logic CfgAckTimeout = 1'b1;

  localparam logic [15:0] UnitTicksRst  = 16'd100;
  localparam logic [7:0]  AckTimeoutRst = 8'd250;
  localparam int unsigned BitsPerByte   = 8;

  // Bus phases, one-hot
  typedef enum logic [13:0] {
    PH_IDLE = 14'h0001,
    PH_S1   = 14'h0002,
    PH_S2   = 14'h0004,
    PH_P1   = 14'h0008,
    PH_P2   = 14'h0010,
    PH_WL   = 14'h0020,
    PH_WH   = 14'h0040,
    PH_WT   = 14'h0080,
    PH_AR   = 14'h0100,
    PH_AP   = 14'h0200,
    PH_RL   = 14'h0400,
    PH_RH   = 14'h0800,
    PH_KL   = 14'h1000,
    PH_KH   = 14'h2000
  } phase_e;

  // One classified tick waiting for the engine
  typedef struct packed {
    cmd_e       op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

endpackage

// ----- rtl/core/i2cm_front.sv -----
// Front end: takes tick beats, classifies the command, queues them.
module i2cm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         command_i,
  input  logic [7:0]         tx_byte_i,
  input  logic               send_ack_i,
  input  logic               sda_in_i,
  output logic               q_valid_o,
  input  logic               q_pop_i,
  output i2cm_pkg::tick_t    q_data_o
);
  import i2cm_pkg::*;

  tick_t      entry;
  tick_t      fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;

  // Map unknown command codes onto no-op
  always_comb begin
    entry.tx_byte  = tx_byte_i;
    entry.send_ack = send_ack_i;
    entry.sda_in   = sda_in_i;
    unique case (command_i)
      CMD_START: entry.op = CMD_START;
      CMD_STOP:  entry.op = CMD_STOP;
      CMD_WRITE: entry.op = CMD_WRITE;
      CMD_READ:  entry.op = CMD_READ;
      default:   entry.op = CMD_NONE;
    endcase
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_data_o   = fifo_q[rd_ptr_q];

  // Two-entry queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push && !q_pop_i) count_q <= count_q + 2'd1;
      else if (!push && q_pop_i) count_q <= count_q - 2'd1;
    end
  end

endmodule

// ----- rtl/core/i2cm_engine.sv -----
// Back end: bus phase sequencer, one tick per popped beat, output register.
module i2cm_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        unit_ticks_i,
  input  logic [7:0]         ack_timeout_i,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  i2cm_pkg::tick_t    q_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               scl_o,
  output logic               sda_out_o,
  output logic               sda_drive_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic [7:0]         rx_byte_o,
  output logic               ack_error_o
);
  import i2cm_pkg::*;

  phase_e      state_q, state_d;
  logic [3:0]  bit_idx_q, bit_idx_d;
  logic [7:0]  shift_q, shift_d;
  logic [16:0] tick_q, tick_d;
  logic [7:0]  poll_q, poll_d;
  logic        ack_q, ack_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        drv_q, drv_d;
  logic        err_q, err_d;
  logic [7:0]  rx_q, rx_d;
  logic        done_d, finish, go, long_ph;
  phase_e      go_st;
  logic [15:0] unit_len;
  logic        out_valid_q;
  logic        out_busy_q, out_done_q;

  assign q_pop_o  = q_valid_i && (!out_valid_q || out_ready_i);
  assign unit_len = (unit_ticks_i == 16'd0) ? 16'd1 : unit_ticks_i;

  // One tick of the phase sequencer
  always_comb begin
    state_d   = state_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    tick_d    = tick_q;
    poll_d    = poll_q;
    ack_d     = ack_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    drv_d     = drv_q;
    err_d     = err_q;
    rx_d      = rx_q;
    done_d    = 1'b0;
    finish    = 1'b0;
    go        = 1'b0;
    go_st     = PH_IDLE;
    long_ph   = 1'b0;

    if (state_q == PH_IDLE) begin
      unique case (q_data_i.op)
        CMD_START: begin
          go = 1'b1; go_st = PH_S1;
        end
        CMD_STOP: begin
          go = 1'b1; go_st = PH_P1;
        end
        CMD_WRITE: begin
          shift_d = q_data_i.tx_byte; bit_idx_d = 4'd0; err_d = 1'b0; poll_d = 8'd0;
          go = 1'b1; go_st = PH_WL;
        end
        CMD_READ: begin
          ack_d = q_data_i.send_ack; bit_idx_d = 4'd0; shift_d = 8'd0;
          go = 1'b1; go_st = PH_RL;
        end
        default: ;
      endcase
    end else if (state_q == PH_AP) begin
      // Acknowledge polling
      if (!q_data_i.sda_in) begin
        scl_d  = 1'b0;
        finish = 1'b1;
      end else if (poll_q >= ack_timeout_i) begin
        err_d = 1'b1;
        go = 1'b1; go_st = PH_P1;
      end else begin
        poll_d = poll_q + 8'd1;
      end
    end else if (tick_q > 17'd1) begin
      tick_d = tick_q - 17'd1;
    end else begin
      unique case (state_q)
        PH_S1: begin go = 1'b1; go_st = PH_S2; end
        PH_S2: begin scl_d = 1'b0; finish = 1'b1; end
        PH_P1: begin go = 1'b1; go_st = PH_P2; end
        PH_P2: finish = 1'b1;
        PH_WL: begin go = 1'b1; go_st = PH_WH; end
        PH_WH: begin go = 1'b1; go_st = PH_WT; end
        PH_WT: begin
          shift_d   = {shift_q[6:0], 1'b0};
          bit_idx_d = bit_idx_q + 4'd1;
          go        = 1'b1;
          go_st     = (bit_idx_d < 4'(BitsPerByte)) ? PH_WL : PH_AR;
        end
        PH_AR: begin go = 1'b1; go_st = PH_AP; end
        PH_RL: begin go = 1'b1; go_st = PH_RH; end
        PH_RH: begin
          shift_d   = {shift_q[6:0], q_data_i.sda_in};
          bit_idx_d = bit_idx_q + 4'd1;
          go        = 1'b1;
          if (bit_idx_d < 4'(BitsPerByte)) begin
            go_st = PH_RL;
          end else begin
            rx_d  = shift_d;
            go_st = PH_KL;
          end
        end
        PH_KL: begin go = 1'b1; go_st = PH_KH; end
        PH_KH: begin scl_d = 1'b0; finish = 1'b1; end
        default: state_d = PH_IDLE;
      endcase
    end

    // Phase entry: line levels and phase length
    if (go) begin
      state_d = go_st;
      unique case (go_st)
        PH_S1: begin scl_d = 1'b1; sda_d = 1'b1; drv_d = 1'b1; long_ph = 1'b1; end
        PH_S2: begin scl_d = 1'b1; sda_d = 1'b0; drv_d = 1'b1; long_ph = 1'b1; end
        PH_P1: begin scl_d = 1'b0; sda_d = 1'b0; drv_d = 1'b1; long_ph = 1'b1; end
        PH_P2: begin scl_d = 1'b1; sda_d = 1'b1; drv_d = 1'b1; long_ph = 1'b1; end
        PH_WL: begin scl_d = 1'b0; sda_d = shift_d[7]; drv_d = 1'b1; end
        PH_WH: scl_d = 1'b1;
        PH_WT: scl_d = 1'b0;
        PH_AR: begin scl_d = 1'b0; sda_d = 1'b1; drv_d = 1'b0; end
        PH_AP: begin scl_d = 1'b1; sda_d = 1'b1; drv_d = 1'b0; poll_d = 8'd0; end
        PH_RL: begin scl_d = 1'b0; sda_d = 1'b1; drv_d = 1'b0; end
        PH_RH: scl_d = 1'b1;
        PH_KL: begin scl_d = 1'b0; sda_d = ~ack_d; drv_d = 1'b1; end
        PH_KH: scl_d = 1'b1;
        default: ;
      endcase
      tick_d = long_ph ? {unit_len, 1'b0} : {1'b0, unit_len};
    end

    if (finish) begin
      state_d = PH_IDLE;
      tick_d  = 17'd0;
      done_d  = 1'b1;
    end
  end

  // Sequencer state, advanced once per popped beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= PH_IDLE;
      bit_idx_q <= 4'd0;
      shift_q   <= 8'd0;
      tick_q    <= 17'd0;
      poll_q    <= 8'd0;
      ack_q     <= 1'b0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      drv_q     <= 1'b1;
      err_q     <= 1'b0;
      rx_q      <= 8'd0;
    end else if (q_pop_o) begin
      state_q   <= state_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      tick_q    <= tick_d;
      poll_q    <= poll_d;
      ack_q     <= ack_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      drv_q     <= drv_d;
      err_q     <= err_d;
      rx_q      <= rx_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_busy_q <= (state_d != PH_IDLE);
      out_done_q <= done_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_o       = scl_q;
  assign sda_out_o   = sda_q;
  assign sda_drive_o = drv_q;
  assign busy_res_o  = out_busy_q;
  assign done_res_o  = out_done_q;
  assign rx_byte_o   = rx_q;
  assign ack_error_o = err_q;

endmodule

// ----- rtl/core/i2c_master_byte_engine_core.sv -----
// I2C master byte engine: one bus tick per beat, front queue plus phase sequencer.
// Throughput: one tick beat per cycle unless the result side stalls; each beat gives
// exactly one result beat. Each beat is registered in the queue stage, then in the
// sequencer stage, and waits in the queue while the result side stalls.
// Reset: bus lines driven high, sequencer idle, unit_ticks 100, ack_timeout 250.
module i2c_master_byte_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        send_ack_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_o,
  output logic        sda_out_o,
  output logic        sda_drive_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  rx_byte_o,
  output logic        ack_error_o
);
  import i2cm_pkg::*;

  logic [15:0] unit_ticks_q;
  logic [7:0]  ack_timeout_q;
  logic        q_valid, q_pop;
  tick_t       q_data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q  <= UnitTicksRst;
      ack_timeout_q <= AckTimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgUnitTicks:  unit_ticks_q  <= cfg_data_i;
        CfgAckTimeout: ack_timeout_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  i2cm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .tx_byte_i  (tx_byte_i),
    .send_ack_i (send_ack_i),
    .sda_in_i   (sda_in_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_data_o   (q_data)
  );

  i2cm_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .unit_ticks_i  (unit_ticks_q),
    .ack_timeout_i (ack_timeout_q),
    .q_valid_i     (q_valid),
    .q_pop_o       (q_pop),
    .q_data_i      (q_data),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .scl_o         (scl_o),
    .sda_out_o     (sda_out_o),
    .sda_drive_o   (sda_drive_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .rx_byte_o     (rx_byte_o),
    .ack_error_o   (ack_error_o)
  );

endmodule
